// ===== src/srtf_pkg.sv =====
// package: shared types, constants and controller states for the srtf scheduler
`timescale 1ns / 1ps

package srtf_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int TIME_W      = 32;
	localparam int DUR_W       = 16;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// token that travels along the cell chain during a selection sweep
	typedef struct packed {
		logic                best_v;
		logic [IDX_W-1:0]    best_idx;
		logic [DUR_W-1:0]    rem;
		logic [TIME_W-1:0]   arr;
		logic                started;
		logic [TIME_W-1:0]   first_start;
		logic                free_v;
		logic [IDX_W-1:0]    free_idx;
	} sweep_tok_t;

	// write command broadcast to every cell, taken by the addressed one
	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    idx;
		logic                valid;
		logic [TIME_W-1:0]   arr;
		logic [DUR_W-1:0]    rem;
		logic                started;
		logic [TIME_W-1:0]   first_start;
	} cell_wr_t;

	typedef struct packed {
		logic [TIME_W-1:0]   job_arrival;
		logic [TIME_W-1:0]   first_start;
		logic [TIME_W-1:0]   completion;
		logic                dropped;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LAUNCH,
		ST_SWEEP,
		ST_DECIDE,
		ST_EXEC,
		ST_INSERT,
		ST_EMIT,
		ST_LOOP,
		ST_DRAINCHK,
		ST_FINISH
	} ctrl_state_t;

endpackage

// ===== src/srtf_cell.sv =====
// one table slot of the scheduler plus its stage of the selection chain
`timescale 1ns / 1ps

module srtf_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [srtf_pkg::IDX_W-1:0]    cell_idx,
	input  srtf_pkg::cell_wr_t            wr,
	input  logic                          go_in,
	input  srtf_pkg::sweep_tok_t          tok_in,
	output logic                          go_out,
	output srtf_pkg::sweep_tok_t          tok_out
);

	logic                          valid_q;
	logic [srtf_pkg::TIME_W-1:0]   arr_q;
	logic [srtf_pkg::DUR_W-1:0]    rem_q;
	logic                          started_q;
	logic [srtf_pkg::TIME_W-1:0]   first_start_q;
	logic                          go_q;
	srtf_pkg::sweep_tok_t          tok_q;
	srtf_pkg::sweep_tok_t          tok_d;
	logic                          better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && wr.idx == cell_idx) begin
			valid_q <= wr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == cell_idx && wr.valid) begin
			arr_q         <= wr.arr;
			rem_q         <= wr.rem;
			started_q     <= wr.started;
			first_start_q <= wr.first_start;
		end
	end

	// strict compare keeps the lower index on a full tie
	assign better = valid_q && (!tok_in.best_v || rem_q < tok_in.rem ||
		(rem_q == tok_in.rem && arr_q < tok_in.arr));

	always_comb begin
		tok_d = tok_in;
		if (better) begin
			tok_d.best_v      = 1'b1;
			tok_d.best_idx    = cell_idx;
			tok_d.rem         = rem_q;
			tok_d.arr         = arr_q;
			tok_d.started     = started_q;
			tok_d.first_start = first_start_q;
		end
		if (!valid_q && !tok_in.free_v) begin
			tok_d.free_v   = 1'b1;
			tok_d.free_idx = cell_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
		end else begin
			go_q <= go_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	assign go_out  = go_q;
	assign tok_out = tok_q;

endmodule

// ===== src/srtf_ctrl.sv =====
// sequencer: simulated time, run and drain loops, result hold and output register
`timescale 1ns / 1ps

module srtf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [47:0]                   s_tdata,   // arrival[31:0], duration[47:32]
	input  logic                          s_tuser,   // has_job
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// job_arrival[31:0], first_start[63:32], completion[95:64]
	output logic [95:0]                   m_tdata,
	output logic                          m_tuser,   // dropped
	output logic                          m_tlast,
	output logic                          sweep_go,
	input  logic                          sweep_done,
	input  srtf_pkg::sweep_tok_t          sweep_tok,
	output srtf_pkg::cell_wr_t            wr
);

	srtf_pkg::ctrl_state_t         state_q, state_d, ret_q;
	logic [srtf_pkg::TIME_W-1:0]   sim_q;
	logic [srtf_pkg::TIME_W-1:0]   arr_in_q;
	logic [srtf_pkg::DUR_W-1:0]    dur_in_q;
	logic                          drain_q;
	logic                          drain_phase_q;
	srtf_pkg::sweep_tok_t          best_q;
	logic                          free_v_q;
	logic [srtf_pkg::IDX_W-1:0]    free_idx_q;
	logic [srtf_pkg::TIME_W-1:0]   t0_q;
	logic [srtf_pkg::TIME_W-1:0]   fr_q;
	srtf_pkg::result_t             res_q;
	srtf_pkg::result_t             hold_q;
	logic                          hold_v_q;
	srtf_pkg::result_t             out_q;
	logic                          out_v_q;
	logic                          out_last_q;

	logic                          out_free;
	logic                          accept;
	logic [srtf_pkg::TIME_W:0]     end_t;
	logic                          fits;
	logic [srtf_pkg::TIME_W-1:0]   start_fr;
	logic                          push;
	logic                          push_last;

	assign out_free = !out_v_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign end_t    = {1'b0, t0_q} + {{(srtf_pkg::TIME_W + 1 - srtf_pkg::DUR_W){1'b0}}, best_q.rem};
	assign fits     = end_t <= {1'b0, arr_in_q};
	assign start_fr = best_q.started ? best_q.first_start :
		((sim_q > best_q.arr) ? sim_q : best_q.arr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srtf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		sweep_go  = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		wr        = '0;
		unique case (state_q)
			srtf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser || s_tlast)) begin
					state_d = srtf_pkg::ST_LAUNCH;
				end
			end
			srtf_pkg::ST_LAUNCH: begin
				sweep_go = 1'b1;
				state_d  = srtf_pkg::ST_SWEEP;
			end
			srtf_pkg::ST_SWEEP: begin
				if (sweep_done) begin
					state_d = srtf_pkg::ST_DECIDE;
				end
			end
			srtf_pkg::ST_DECIDE: begin
				if (!drain_phase_q) begin
					if (sim_q >= arr_in_q || !best_q.best_v) begin
						state_d = srtf_pkg::ST_INSERT;
					end else begin
						state_d = srtf_pkg::ST_EXEC;
					end
				end else if (!best_q.best_v) begin
					state_d = srtf_pkg::ST_FINISH;
				end else begin
					state_d = srtf_pkg::ST_EXEC;
				end
			end
			srtf_pkg::ST_EXEC: begin
				wr.en  = 1'b1;
				wr.idx = best_q.best_idx;
				if (!drain_phase_q && !fits) begin
					// preempted at the arrival, keep what is left
					wr.valid       = 1'b1;
					wr.arr         = best_q.arr;
					wr.rem         = srtf_pkg::DUR_W'(end_t - {1'b0, arr_in_q});
					wr.started     = 1'b1;
					wr.first_start = fr_q;
					state_d        = srtf_pkg::ST_INSERT;
				end else begin
					wr.valid = 1'b0;
					state_d  = srtf_pkg::ST_EMIT;
				end
			end
			srtf_pkg::ST_INSERT: begin
				if (free_v_q) begin
					wr.en          = 1'b1;
					wr.idx         = free_idx_q;
					wr.valid       = 1'b1;
					wr.arr         = arr_in_q;
					wr.rem         = dur_in_q;
					wr.started     = 1'b0;
					wr.first_start = '0;
					state_d        = srtf_pkg::ST_DRAINCHK;
				end else begin
					state_d = srtf_pkg::ST_EMIT;
				end
			end
			srtf_pkg::ST_EMIT: begin
				if (!hold_v_q || out_free) begin
					push    = hold_v_q;
					state_d = ret_q;
				end
			end
			srtf_pkg::ST_LOOP: begin
				if (sim_q >= arr_in_q) begin
					state_d = srtf_pkg::ST_INSERT;
				end else begin
					state_d = srtf_pkg::ST_LAUNCH;
				end
			end
			srtf_pkg::ST_DRAINCHK: begin
				if (drain_q) begin
					state_d = srtf_pkg::ST_LAUNCH;
				end else begin
					state_d = srtf_pkg::ST_FINISH;
				end
			end
			srtf_pkg::ST_FINISH: begin
				if (!hold_v_q) begin
					state_d = srtf_pkg::ST_IDLE;
				end else if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = srtf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srtf_pkg::ST_IDLE;
			end
		endcase
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sim_q         <= '0;
			drain_phase_q <= 1'b0;
			hold_v_q      <= 1'b0;
			out_v_q       <= 1'b0;
			ret_q         <= srtf_pkg::ST_IDLE;
		end else begin
			if (push) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				srtf_pkg::ST_IDLE: begin
					if (accept) begin
						drain_phase_q <= !s_tuser;
					end
				end
				srtf_pkg::ST_DECIDE: begin
					if (!drain_phase_q && sim_q < arr_in_q) begin
						if (!best_q.best_v) begin
							sim_q <= arr_in_q;
						end else if (!best_q.started && start_fr > sim_q) begin
							sim_q <= start_fr;
						end
					end else if (drain_phase_q && best_q.best_v && !best_q.started &&
						start_fr > sim_q) begin
						sim_q <= start_fr;
					end
				end
				srtf_pkg::ST_EXEC: begin
					if (!drain_phase_q) begin
						if (fits) begin
							sim_q <= end_t[srtf_pkg::TIME_W-1:0];
							ret_q <= srtf_pkg::ST_LOOP;
						end else begin
							sim_q <= arr_in_q;
						end
					end else begin
						sim_q <= end_t[srtf_pkg::TIME_W] ? srtf_pkg::TIME_MAX :
							end_t[srtf_pkg::TIME_W-1:0];
						ret_q <= srtf_pkg::ST_LAUNCH;
					end
				end
				srtf_pkg::ST_INSERT: begin
					if (!free_v_q) begin
						ret_q <= srtf_pkg::ST_DRAINCHK;
					end
				end
				srtf_pkg::ST_EMIT: begin
					if (!hold_v_q || out_free) begin
						hold_v_q <= 1'b1;
					end
				end
				srtf_pkg::ST_DRAINCHK: begin
					drain_phase_q <= 1'b1;
				end
				srtf_pkg::ST_FINISH: begin
					if (out_free) begin
						hold_v_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			arr_in_q <= s_tdata[31:0];
			dur_in_q <= s_tdata[47:32];
			drain_q  <= s_tlast;
		end
		if (state_q == srtf_pkg::ST_SWEEP && sweep_done) begin
			best_q     <= sweep_tok;
			free_v_q   <= sweep_tok.free_v;
			free_idx_q <= sweep_tok.free_idx;
		end
		if (state_q == srtf_pkg::ST_DECIDE) begin
			fr_q <= start_fr;
			t0_q <= best_q.started ? sim_q : start_fr;
		end
		if (state_q == srtf_pkg::ST_EXEC && (drain_phase_q || fits)) begin
			res_q.job_arrival <= best_q.arr;
			res_q.first_start <= fr_q;
			res_q.completion  <= (drain_phase_q && end_t[srtf_pkg::TIME_W]) ?
				srtf_pkg::TIME_MAX : end_t[srtf_pkg::TIME_W-1:0];
			res_q.dropped     <= 1'b0;
			// a slot freed here may be the lowest free one for the insertion
			if (!free_v_q || best_q.best_idx < free_idx_q) begin
				free_v_q   <= 1'b1;
				free_idx_q <= best_q.best_idx;
			end
		end
		if (state_q == srtf_pkg::ST_INSERT && !free_v_q) begin
			res_q.job_arrival <= arr_in_q;
			res_q.first_start <= '0;
			res_q.completion  <= '0;
			res_q.dropped     <= 1'b1;
		end
		if (state_q == srtf_pkg::ST_EMIT && (!hold_v_q || out_free)) begin
			hold_q <= res_q;
		end
		if (push) begin
			out_q      <= hold_q;
			out_last_q <= push_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.completion, out_q.first_start, out_q.job_arrival};
	assign m_tuser  = out_q.dropped;
	assign m_tlast  = out_last_q;

endmodule

// ===== src/shortest_remaining_time_scheduler_unit.sv =====
// top level: chain of slot cells and the scheduling sequencer
`timescale 1ns / 1ps

// Shortest-remaining-time-first scheduler over simulated time.
// Input channel s_*: one item per job arrival (arrival, duration), flagged by
// s_tuser = has_job; s_tlast = end of workload drains every pending job.
// Output channel m_*: one item per completed or dropped job; m_tlast marks
// the final result caused by an input item, m_tuser marks a dropped job.
// Each selection sweeps a token through the TABLE_DEPTH cells, one cell per
// cycle. A selection that completes a job before the arrival goes through
// launch, sweep, decide, exec and emit, then the loop check; one during a
// drain returns from emit straight to launch.
// An item with neither flag gives no result.
// One item is worked at a time; s_tready is high only between items.
// Results are held one deep so the last flag can be set, then loaded into
// the output register; a stalled receiver holds the sequencer at its next
// result while the register waits, and the next item is taken once all of
// the current item's results have reached the register.
// Reset clears every slot valid flag and simulated time at once; no pass
// over the table is needed.

module shortest_remaining_time_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // arrival[31:0], duration[47:32]
	input  logic        s_tuser,   // has_job
	input  logic        s_tlast,   // end_of_workload
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // job_arrival[31:0], first_start[63:32], completion[95:64]
	output logic        m_tuser,   // dropped
	output logic        m_tlast    // last_result
);

	logic                          go_chain  [srtf_pkg::TABLE_DEPTH+1];
	srtf_pkg::sweep_tok_t          tok_chain [srtf_pkg::TABLE_DEPTH+1];
	srtf_pkg::cell_wr_t            wr;

	// empty token enters the head of the chain
	assign tok_chain[0] = '0;

	genvar i;
	generate
		for (i = 0; i < srtf_pkg::TABLE_DEPTH; i++) begin : g_cell
			srtf_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cell_idx (srtf_pkg::IDX_W'(i)),
				.wr       (wr),
				.go_in    (go_chain[i]),
				.tok_in   (tok_chain[i]),
				.go_out   (go_chain[i+1]),
				.tok_out  (tok_chain[i+1])
			);
		end
	endgenerate

	srtf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.sweep_go   (go_chain[0]),
		.sweep_done (go_chain[srtf_pkg::TABLE_DEPTH]),
		.sweep_tok  (tok_chain[srtf_pkg::TABLE_DEPTH]),
		.wr         (wr)
	);

endmodule

// ===== test/testbench.sv =====
// testbench: srtf scheduler checked item by item against a scheduling model, with random stalls
`timescale 1ns / 1ps

module testbench;

	typedef struct packed {
		logic [srtf_pkg::TIME_W-1:0] job_arrival;
		logic [srtf_pkg::TIME_W-1:0] first_start;
		logic [srtf_pkg::TIME_W-1:0] completion;
		logic                        dropped;
		logic                        last;
	} job_outcome_t;

	localparam int SWEEP_CYCLES = srtf_pkg::TABLE_DEPTH + 4;
	localparam int HOLD_CYCLES  = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // arrival[31:0], duration[47:32]
	logic        s_tuser;   // has_job
	logic        s_tlast;   // end_of_workload
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // job_arrival[31:0], first_start[63:32], completion[95:64]
	logic        m_tuser;   // dropped
	logic        m_tlast;   // last_result

	shortest_remaining_time_scheduler_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// scheduling model state
	bit                          held_valid       [srtf_pkg::TABLE_DEPTH];
	bit [srtf_pkg::TIME_W-1:0]   held_arrival     [srtf_pkg::TABLE_DEPTH];
	bit [srtf_pkg::DUR_W-1:0]    held_left        [srtf_pkg::TABLE_DEPTH];
	bit                          held_started     [srtf_pkg::TABLE_DEPTH];
	bit [srtf_pkg::TIME_W-1:0]   held_first_start [srtf_pkg::TABLE_DEPTH];
	bit [srtf_pkg::TIME_W-1:0]   sched_time;

	job_outcome_t expected_completions[$];
	int           mismatch_count;
	bit           steady_phase;
	bit           hold_request;
	int           stall_left;

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	function automatic int idle_cycles();
		int r;
		if (steady_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_next();
		int best;
		int i;
		best = -1;
		for (i = 0; i < srtf_pkg::TABLE_DEPTH; i++) begin
			if (held_valid[i] && (best < 0 || held_left[i] < held_left[best] ||
			    (held_left[i] == held_left[best] && held_arrival[i] < held_arrival[best])))
				best = i;
		end
		return best;
	endfunction

	function automatic void start_job(int s);
		if (!held_started[s]) begin
			held_started[s]     = 1'b1;
			held_first_start[s] = (sched_time > held_arrival[s]) ? sched_time :
				held_arrival[s];
			sched_time          = held_first_start[s];
		end
	endfunction

	function automatic job_outcome_t outcome(bit [srtf_pkg::TIME_W-1:0] arr,
	                                         bit [srtf_pkg::TIME_W-1:0] fr,
	                                         bit [srtf_pkg::TIME_W-1:0] comp, bit drop);
		job_outcome_t r;
		r.job_arrival = arr;
		r.first_start = fr;
		r.completion  = comp;
		r.dropped     = drop;
		r.last        = 1'b0;
		return r;
	endfunction

	// works out every completion or drop that one accepted item causes
	function automatic void schedule_item(bit [srtf_pkg::TIME_W-1:0] arr,
	                                      bit [srtf_pkg::DUR_W-1:0] dur,
	                                      bit has_job, bit drain);
		job_outcome_t batch[$];
		bit [srtf_pkg::TIME_W:0] end_t;
		int s;
		int i;
		if (has_job) begin
			while (sched_time < arr) begin
				s = pick_next();
				if (s < 0) begin
					sched_time = arr;
					break;
				end
				start_job(s);
				end_t = {1'b0, sched_time} + held_left[s];
				if (end_t <= {1'b0, arr}) begin
					sched_time    = end_t[srtf_pkg::TIME_W-1:0];
					held_valid[s] = 1'b0;
					batch.insert(batch.size(), outcome(held_arrival[s],
						held_first_start[s], sched_time, 1'b0));
				end else begin
					// preempted at the arrival
					held_left[s] = srtf_pkg::DUR_W'(end_t - {1'b0, arr});
					sched_time   = arr;
					break;
				end
			end
			s = -1;
			for (i = 0; i < srtf_pkg::TABLE_DEPTH; i++) begin
				if (s < 0 && !held_valid[i])
					s = i;
			end
			if (s < 0) begin
				batch.insert(batch.size(), outcome(arr, '0, '0, 1'b1));
			end else begin
				held_valid[s]       = 1'b1;
				held_arrival[s]     = arr;
				held_left[s]        = dur;
				held_started[s]     = 1'b0;
				held_first_start[s] = '0;
			end
		end
		if (drain) begin
			s = pick_next();
			while (s >= 0) begin
				start_job(s);
				end_t         = {1'b0, sched_time} + held_left[s];
				sched_time    = end_t[srtf_pkg::TIME_W] ? srtf_pkg::TIME_MAX :
					end_t[srtf_pkg::TIME_W-1:0];
				held_left[s]  = '0;
				held_valid[s] = 1'b0;
				batch.insert(batch.size(), outcome(held_arrival[s],
					held_first_start[s], sched_time, 1'b0));
				s = pick_next();
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			expected_completions.insert(expected_completions.size(), batch[k]);
	endfunction

	task automatic send_item(input logic [srtf_pkg::TIME_W-1:0] arr,
	                         input logic [srtf_pkg::DUR_W-1:0] dur,
	                         input logic has_job, input logic drain);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {dur, arr};
		s_tuser  <= has_job;
		s_tlast  <= drain;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		schedule_item(arr, dur, has_job, drain);
	endtask

	task automatic check_field(input string what, input logic [srtf_pkg::TIME_W-1:0] want,
	                           input logic [srtf_pkg::TIME_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// receiver: random gaps, plus one long hold-off on request
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				stall_left = idle_cycles();
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		job_outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_completions.size() == 0) begin
				$display("%0t ns: unexpected item, expected none, actual arr %h fr %h comp %h",
				         $time, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]);
				mismatch_count++;
			end else begin
				want = expected_completions[0];
				expected_completions.delete(0);
				check_field("job_arrival", want.job_arrival, m_tdata[31:0]);
				check_field("first_start", want.first_start, m_tdata[63:32]);
				check_field("completion", want.completion, m_tdata[95:64]);
				check_field("dropped", {31'b0, want.dropped}, {31'b0, m_tuser});
				check_field("last_result", {31'b0, want.last}, {31'b0, m_tlast});
			end
		end
	end

	task automatic test_empty_items();
		// neither flag, then an end marker on an empty table: no results
		send_item($urandom, srtf_pkg::DUR_W'($urandom), 1'b0, 1'b0);
		send_item(32'd0, 16'd0, 1'b0, 1'b1);
	endtask

	task automatic test_preemption_and_ties();
		bit [srtf_pkg::TIME_W-1:0] t;
		send_item(32'd0, 16'd0, 1'b1, 1'b0);
		send_item(32'd2, 16'd10, 1'b1, 1'b0);
		send_item(32'd4, 16'd3, 1'b1, 1'b0);     // preempts the longer job
		send_item(32'd20, 16'd1, 1'b1, 1'b0);
		send_item(32'd21, 16'd5, 1'b1, 1'b0);    // previous job ends exactly here
		send_item(32'd40, 16'd4, 1'b1, 1'b1);
		// arrivals behind simulated time, equal remaining times
		send_item(32'd41, 16'd3, 1'b1, 1'b0);
		send_item(32'd42, 16'd3, 1'b1, 1'b0);
		send_item(32'd42, 16'd3, 1'b1, 1'b1);
		t = sched_time;
		send_item(t + 32'd6, 16'hFFFF, 1'b1, 1'b1);
		t = sched_time;
		send_item(t + 32'd3, 16'd9, 1'b1, 1'b0);
		send_item(32'd0, 16'd0, 1'b0, 1'b1);     // end marker alone drains
	endtask

	task automatic test_full_table();
		bit [srtf_pkg::TIME_W-1:0] t;
		int i;
		t = sched_time + 32'd10;
		for (i = 0; i < srtf_pkg::TABLE_DEPTH; i++)
			send_item(t, srtf_pkg::DUR_W'((i * 5) % 7), 1'b1, 1'b0);
		// one more than the table holds, then drain: drop plus every stored job
		send_item(t, 16'd2, 1'b1, 1'b1);
	endtask

	task automatic test_output_hold();
		bit [srtf_pkg::TIME_W-1:0] t;
		int i;
		hold_request = 1'b1;
		t = sched_time;
		for (i = 0; i < 14; i++) begin
			t = t + 32'd3;
			send_item(t, srtf_pkg::DUR_W'($urandom_range(1, 2)), 1'b1, i == 13);
		end
	endtask

	task automatic test_random_workloads();
		bit [srtf_pkg::TIME_W-1:0] arr;
		bit [srtf_pkg::DUR_W-1:0]  dur;
		int sent;
		int len;
		int mode;
		int k;
		int r;
		bit closed;
		sent = 0;
		while (sent < 230) begin
			mode         = $urandom_range(0, 9);
			len          = $urandom_range(1, 24);
			closed       = ($urandom_range(0, 7) != 0);
			steady_phase = ($urandom_range(0, 5) == 0);
			arr = sched_time;
			if (arr > 40 && $urandom_range(0, 3) == 0)
				arr = arr - $urandom_range(0, 40);
			for (k = 0; k < len; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_item($urandom, srtf_pkg::DUR_W'($urandom), 1'b0, 1'b0);
				if (mode < 6)
					arr = arr + $urandom_range(0, 12);
				else if (mode < 8)
					arr = arr + (($urandom_range(0, 7) == 0) ? 1 : 0);   // burst fills the table
				else
					arr = arr + $urandom_range(0, 1 << 20);
				r = $urandom_range(0, 99);
				if (r < 5)
					dur = srtf_pkg::DUR_W'($urandom);
				else if (r < 8)
					dur = 16'hFFFF;
				else if (r < 12)
					dur = 16'd0;
				else
					dur = srtf_pkg::DUR_W'($urandom_range(1, 20));
				send_item(arr, dur, $urandom_range(0, 19) != 0,
				          (closed && k == len - 1) || $urandom_range(0, 29) == 0);
				sent++;
			end
		end
		steady_phase = 1'b0;
	endtask

	task automatic test_time_saturation();
		send_item(32'h5555_5555, 16'd9, 1'b1, 1'b0);
		send_item(32'hAAAA_AAAA, 16'hFFFF, 1'b1, 1'b0);
		send_item(32'hFFFF_FFF0, 16'hFFFF, 1'b1, 1'b0);
		send_item(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
		// simulated time is pinned at its maximum from here on
		send_item(32'd5, 16'd1, 1'b1, 1'b1);
	endtask

	initial begin
		int i;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = 1'b0;
		s_tlast        = 1'b0;
		mismatch_count = 0;
		steady_phase   = 1'b0;
		hold_request   = 1'b0;
		sched_time     = '0;
		for (i = 0; i < srtf_pkg::TABLE_DEPTH; i++)
			held_valid[i] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_items();
		test_preemption_and_ties();
		test_full_table();
		test_output_hold();
		test_random_workloads();
		test_time_saturation();
		s_tvalid <= 1'b0;
		while (expected_completions.size() != 0)
			@(posedge clk);
		repeat (2 * SWEEP_CYCLES + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
